/* sv/sem_pkg.sv */
// shared types and constants for the sobel edge magnitude block
package sem_pkg;

  localparam int PIX_W  = 8;
  localparam int GRAD_W = 11;
  localparam int SUM_W  = 21;
  localparam int STEP_W = 3;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_DELIVER
  } sem_state_t;

endpackage

/* sv/sem_ram.sv */
// generic single port write, registered read memory
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/sem_root.sv */
// iterative rounded square root, one result bit per cycle
module sem_root
  import sem_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] sum,
  output logic             done,
  output logic [PIX_W-1:0] root
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  s;
  logic [PIX_W-1:0]  trial;
  logic [2*PIX_W-1:0] prod;
  logic [2*PIX_W:0]  lhs;

  // trial n is kept when n*n - n + 1 <= s, which is monotonic for n >= 1
  assign trial = root | (PIX_W'(1) << step);
  assign prod  = trial * trial;
  assign lhs   = {1'b0, prod} - (2*PIX_W+1)'(trial) + (2*PIX_W+1)'(1);
  assign done  = busy && (step == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s    <= sum;
      root <= '0;
      step <= STEP_W'(PIX_W - 1);
    end else if (busy) begin
      if (SUM_W'(lhs) <= s) begin
        root <= trial;
      end
      step <= step - STEP_W'(1);
    end
  end

endmodule

/* sv/sobel_edge_magnitude_rgb.sv */
// sobel 3x3 gradient magnitude over an rgb raster stream
//
// pixels arrive on in_valid/in_ready in raster order, one transaction per
// pixel or flush item; results leave on out_valid/out_ready, each one row and
// one pixel behind its centre pixel, so width+1 flush items drain a frame.
// configuration (index 0 image_width, index 1 image_height) is taken on
// cfg_valid and restarts the frame; write it only while the block is idle.
// each pixel reads both row memories at its column, and the data returns in
// the next cycle, when the memories are written back and the window shifts.
// an item with no result goes from the read state back to idle; an item with a
// result goes on through memory read, gradient sums, squares, then an 8-step
// bit-serial root unit per channel; out_valid is set from the deliver state.
// a finished result sits in the output register, and the next pixel is
// accepted while it waits; only a second result waits for out_ready.
// reset clears the stream position, window and configuration to 1024x1024;
// row memory contents are never cleared since unwritten entries are masked.
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        is_flush,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  edge_red,
  output logic [7:0]  edge_green,
  output logic [7:0]  edge_blue,
  output logic        end_of_row,
  output logic        end_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = 14;
  localparam int PW = 3 * PIX_W;

  sem_state_t state, state_next;

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [WW-1:0] eff_w;
  logic [RW-1:0] eff_h;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_norm;
  logic [CW-1:0] cur_col;
  logic [PW-1:0] pix;
  logic [PW-1:0] up_data;
  logic [PW-1:0] lo_data;
  logic [PW-1:0] win [3][3];

  logic          top_out, bot_out, left_out, right_out;
  logic          res_ok;
  logic          valid_pos;
  logic [RW-1:0] rc;
  logic [WW-1:0] cc;
  logic [WW-1:0] cn;

  logic signed [GRAD_W-1:0]   mv [3][3][3];
  logic signed [GRAD_W-1:0]   gx_c [3];
  logic signed [GRAD_W-1:0]   gy_c [3];
  logic signed [GRAD_W-1:0]   gx [3];
  logic signed [GRAD_W-1:0]   gy [3];
  logic signed [2*GRAD_W-1:0] sqx [3];
  logic signed [2*GRAD_W-1:0] sqy [3];
  logic [SUM_W-1:0]           s_c [3];
  logic [SUM_W-1:0]           s [3];
  logic [2:0]                 root_done;
  logic [PIX_W-1:0]           root_val [3];
  logic                       root_start;
  logic                       accept;
  logic                       deliver;

  // effective frame size
  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (14'(image_width) > 14'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    eff_h = (image_height == '0) ? RW'(1) : RW'(image_height);
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign col_norm  = (WW'(col) >= eff_w) ? '0 : col;
  assign root_start = (state == ST_START);
  assign deliver   = (state == ST_DELIVER) && (!out_valid || out_ready);

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (cur_col),
    .wdata (lo_data),
    .re    (accept),
    .raddr (col_norm),
    .rdata (up_data)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (cur_col),
    .wdata (pix),
    .re    (accept),
    .raddr (col_norm),
    .rdata (lo_data)
  );

  // position of the result that this item completes
  always_comb begin
    cn = WW'(cur_col) + WW'(1);
    if (cur_col != '0) begin
      valid_pos = (row >= RW'(1));
      rc        = row - RW'(1);
      cc        = WW'(cur_col) - WW'(1);
    end else begin
      valid_pos = (row >= RW'(2));
      rc        = row - RW'(2);
      cc        = eff_w - WW'(1);
    end
    res_ok = valid_pos && (rc < eff_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = ST_READ;
      ST_READ:    state_next = res_ok ? ST_GRAD : ST_IDLE;
      ST_GRAD:    state_next = ST_SQUARE;
      ST_SQUARE:  state_next = ST_START;
      ST_START:   state_next = ST_ROOT;
      ST_ROOT:    if (root_done[0]) state_next = ST_DELIVER;
      ST_DELIVER: if (deliver) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  function automatic logic bot_out_c(input logic [RW-1:0] r);
    return (r + RW'(1)) >= eff_h;
  endfunction

  // configuration and stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
      col          <= '0;
      row          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data[10:0];
          col         <= '0;
          row         <= '0;
        end
        CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
          col          <= '0;
          row          <= '0;
        end
        default: ;
      endcase
    end else if (state == ST_READ) begin
      if (res_ok && bot_out_c(rc) && (cc + WW'(1) >= eff_w)) begin
        col <= '0;
        row <= '0;
      end else if (cn >= eff_w) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= CW'(cn);
      end
    end
  end

  // window and per-item registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (state == ST_READ) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up_data;
      win[1][2] <= lo_data;
      win[2][2] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_col <= col_norm;
      pix     <= is_flush ? '0 : {blue, green, red};
    end
    if (state == ST_READ) begin
      top_out   <= (rc == '0);
      bot_out   <= bot_out_c(rc);
      left_out  <= (cc == '0);
      right_out <= (cc + WW'(1) >= eff_w);
    end
  end

  // masked window, gradient sums, squares and squared magnitude sums
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r == 0 && top_out) || (r == 2 && bot_out) ||
              (c == 0 && left_out) || (c == 2 && right_out)) begin
            mv[ch][r][c] = '0;
          end else begin
            mv[ch][r][c] = $signed({3'b000, win[r][c][8*ch +: 8]});
          end
        end
      end
      gx_c[ch] = mv[ch][0][2] + mv[ch][1][2] + mv[ch][1][2] + mv[ch][2][2]
               - mv[ch][0][0] - mv[ch][1][0] - mv[ch][1][0] - mv[ch][2][0];
      gy_c[ch] = mv[ch][2][0] + mv[ch][2][1] + mv[ch][2][1] + mv[ch][2][2]
               - mv[ch][0][0] - mv[ch][0][1] - mv[ch][0][1] - mv[ch][0][2];
      sqx[ch]  = gx[ch] * gx[ch];
      sqy[ch]  = gy[ch] * gy[ch];
      s_c[ch]  = SUM_W'($unsigned(sqx[ch]) + $unsigned(sqy[ch]));
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (state == ST_GRAD) begin
        gx[ch] <= gx_c[ch];
        gy[ch] <= gy_c[ch];
      end
      if (state == ST_SQUARE) begin
        s[ch] <= s_c[ch];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_root
    sem_root u_root (
      .clk   (clk),
      .rst   (rst),
      .start (root_start),
      .sum   (s[ch]),
      .done  (root_done[ch]),
      .root  (root_val[ch])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      edge_red     <= root_val[0];
      edge_green   <= root_val[1];
      edge_blue    <= root_val[2];
      end_of_row   <= right_out;
      end_of_frame <= right_out && bot_out;
    end
  end

`ifndef ASSERT_OFF
  a_root_in_root_state: assert property (@(posedge clk) disable iff (rst)
    root_done[0] |-> state == ST_ROOT)
    else $error("root unit finished outside the root state");

  a_root_lanes_together: assert property (@(posedge clk) disable iff (rst)
    (root_done[0] == root_done[1]) && (root_done[0] == root_done[2]))
    else $error("channel root units out of step");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_READ)
    else $error("accepted transaction did not start a memory read");

  a_eof_ends_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_frame) |-> end_of_row)
    else $error("end of frame without end of row");
`endif

endmodule
